[hdl/rr_pkg.sv]
`default_nettype none
package rr_pkg;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int QUAT_FRAC_BITS_DEF  = 30;
  // quotient bits produced by the divider; magnitude clamps at 2^40
  localparam int QUOT_BITS = 41;
  localparam logic [QUOT_BITS-1:0] QUOT_LIMIT = {1'b1, {(QUOT_BITS-1){1'b0}}};
  localparam logic signed [31:0] RES_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] RES_MIN = 32'sh8000_0000;
endpackage
`default_nettype wire

[hdl/reprojection_residual.sv]
// Path from an accepted input word to its result word: 6 arithmetic stages,
//   41 restoring-divider stages and 1 output stage.
// Throughput: one word per cycle; the 41 divider steps are unrolled into stages.
// A stall on the output freezes the whole pipeline, nothing is lost.
// Reset (rst, synchronous) clears all stage valid bits.
`default_nettype none
module reprojection_residual import rr_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int QUAT_FRAC_BITS  = QUAT_FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // quat_w, quat_x, quat_y, quat_z, trans_x, trans_y, trans_z,
  // point_x, point_y, point_z, observed_x, observed_y (32 bits each)
  input  wire logic [383:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // residual_x [31:0], residual_y [63:32]
  output logic [63:0]       m_tdata,
  // depth_invalid [0], saturated [1]
  output logic [1:0]        m_tuser
);
  localparam int Q   = QUAT_FRAC_BITS;
  localparam int C   = COORD_FRAC_BITS;
  localparam int TPW = 65 - Q;          // twice-product width
  localparam int EW  = TPW + 2;         // unclamped matrix entry
  localparam int RW  = Q + 2;           // clamped matrix entry
  localparam int MPW = RW + 32;         // entry times coordinate
  localparam int AW  = RW + 34;         // sum of three
  localparam int PW  = 37;              // camera point
  localparam int MW  = PW;              // magnitude
  localparam int NW  = MW + C;          // dividend
  localparam int RMW = MW + 1;          // partial remainder
  localparam int QB  = QUOT_BITS;

  localparam logic signed [EW-1:0] ONE_E = EW'(1) << Q;
  localparam logic signed [RW-1:0] ONE_R = RW'(1) << Q;
  localparam logic signed [AW-1:0] HALF  = AW'(1) << (Q - 1);

  function automatic logic signed [RW-1:0] clamp_r(input logic signed [EW-1:0] v);
    logic signed [RW-1:0] r;
    if (v > EW'(ONE_R)) r = ONE_R;
    else if (v < -EW'(ONE_R)) r = -ONE_R;
    else r = v[RW-1:0];
    return r;
  endfunction

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: nine quaternion pair products
  logic signed [31:0] qc [4];
  logic signed [31:0] tin [3];
  logic signed [31:0] vin [3];
  always_comb begin
    for (int k = 0; k < 4; k++) qc[k] = $signed(s_tdata[32*k +: 32]);
    for (int k = 0; k < 3; k++) begin
      tin[k] = $signed(s_tdata[128 + 32*k +: 32]);
      vin[k] = $signed(s_tdata[224 + 32*k +: 32]);
    end
  end

  // order: xx yy zz xy xz yz wx wy wz
  logic signed [31:0]    pa [9];
  logic signed [31:0]    pb [9];
  logic signed [TPW-1:0] tp_next [9];
  always_comb begin
    pa = '{qc[1], qc[2], qc[3], qc[1], qc[1], qc[2], qc[0], qc[0], qc[0]};
    pb = '{qc[1], qc[2], qc[3], qc[2], qc[3], qc[3], qc[1], qc[2], qc[3]};
    for (int k = 0; k < 9; k++) begin
      tp_next[k] = TPW'((64'(pa[k]) * 64'(pb[k])) >>> (Q - 1));
    end
  end

  logic                  v1, v2, v3, v4, v5;
  logic signed [TPW-1:0] tp [9];
  logic signed [31:0]    t1 [3], t2 [3], t3 [3], t4 [3], t5 [3];
  logic signed [31:0]    c1 [3], c2 [3];
  logic signed [31:0]    ob1 [2], ob2 [2], ob3 [2], ob4 [2], ob5 [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      tp  <= tp_next;
      t1  <= tin;
      c1  <= vin;
      ob1 <= '{$signed(s_tdata[320 +: 32]), $signed(s_tdata[352 +: 32])};
    end
  end

  // stage 2: rotation matrix
  logic signed [EW-1:0] e [9];
  logic signed [RW-1:0] rm_next [9];
  logic signed [RW-1:0] rm [9];
  always_comb begin
    e[0] = ONE_E - EW'(tp[1]) - EW'(tp[2]);
    e[1] = EW'(tp[3]) - EW'(tp[8]);
    e[2] = EW'(tp[4]) + EW'(tp[7]);
    e[3] = EW'(tp[3]) + EW'(tp[8]);
    e[4] = ONE_E - EW'(tp[0]) - EW'(tp[2]);
    e[5] = EW'(tp[5]) - EW'(tp[6]);
    e[6] = EW'(tp[4]) - EW'(tp[7]);
    e[7] = EW'(tp[5]) + EW'(tp[6]);
    e[8] = ONE_E - EW'(tp[0]) - EW'(tp[1]);
    for (int k = 0; k < 9; k++) rm_next[k] = clamp_r(e[k]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rm <= rm_next; t2 <= t1; c2 <= c1; ob2 <= ob1;
    end
  end

  // stage 3: matrix times point
  logic signed [MPW-1:0] mp [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) mp[k] <= MPW'(rm[k]) * MPW'(c2[k % 3]);
      t3 <= t2; ob3 <= ob2;
    end
  end

  // stage 4: row sums
  logic signed [AW-1:0] acc [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        acc[k] <= AW'(mp[3*k]) + AW'(mp[3*k+1]) + AW'(mp[3*k+2]);
      end
      t4 <= t3; ob4 <= ob3;
    end
  end

  // stage 5: round, drop fraction, add translation
  logic signed [AW-1:0] sh [3];
  logic signed [PW-1:0] pc_next [3];
  logic signed [PW-1:0] pc [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sh[k]      = (acc[k] + HALF) >>> Q;
      pc_next[k] = $signed({sh[k][PW-2], sh[k][PW-2:0]}) + PW'(t4[k]);
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pc <= pc_next; ob5 <= ob4;
    end
  end

  // stage 6: magnitudes, signs, divider set-up
  logic [MW-1:0]  mag [3];
  logic [NW-1:0]  nx0, ny0;
  logic [RMW-1:0] rx0, ry0;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = pc[k][PW-1] ? MW'(-pc[k]) : MW'(pc[k]);
    end
    nx0 = {mag[0], {C{1'b0}}};
    ny0 = {mag[1], {C{1'b0}}};
    rx0 = RMW'(nx0[NW-1:QB]);
    ry0 = RMW'(ny0[NW-1:QB]);
  end

  logic           dv   [QB+1];
  logic [RMW-1:0] rx   [QB+1];
  logic [RMW-1:0] ry   [QB+1];
  logic [QB-1:0]  qx   [QB+1];
  logic [QB-1:0]  qy   [QB+1];
  logic [NW-1:0]  nx   [QB+1];
  logic [NW-1:0]  ny   [QB+1];
  logic [MW-1:0]  dd   [QB+1];
  logic           ovx  [QB+1];
  logic           ovy  [QB+1];
  logic           ngx  [QB+1];
  logic           ngy  [QB+1];
  logic           zr   [QB+1];
  logic signed [31:0] obd [QB+1][2];

  always_ff @(posedge clk) begin
    if (adv) begin
      rx[0]  <= rx0;
      ry[0]  <= ry0;
      qx[0]  <= '0;
      qy[0]  <= '0;
      nx[0]  <= nx0;
      ny[0]  <= ny0;
      dd[0]  <= mag[2];
      ovx[0] <= rx0 >= RMW'(mag[2]);
      ovy[0] <= ry0 >= RMW'(mag[2]);
      ngx[0] <= pc[0][PW-1] ^ pc[2][PW-1];
      ngy[0] <= pc[1][PW-1] ^ pc[2][PW-1];
      zr[0]  <= pc[2] == '0;
      obd[0] <= ob5;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [RMW-1:0] tx, ty;
    logic           gx, gy;
    always_comb begin
      tx = {rx[i][RMW-2:0], nx[i][QB-1-i]};
      ty = {ry[i][RMW-2:0], ny[i][QB-1-i]};
      gx = tx >= RMW'(dd[i]);
      gy = ty >= RMW'(dd[i]);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rx[i+1]  <= gx ? tx - RMW'(dd[i]) : tx;
        ry[i+1]  <= gy ? ty - RMW'(dd[i]) : ty;
        qx[i+1]  <= {qx[i][QB-2:0], gx};
        qy[i+1]  <= {qy[i][QB-2:0], gy};
        nx[i+1]  <= nx[i];
        ny[i+1]  <= ny[i];
        dd[i+1]  <= dd[i];
        ovx[i+1] <= ovx[i];
        ovy[i+1] <= ovy[i];
        ngx[i+1] <= ngx[i];
        ngy[i+1] <= ngy[i];
        zr[i+1]  <= zr[i];
        obd[i+1] <= obd[i];
      end
    end
  end

  // output stage: clamp, sign, subtract observation, saturate; zero depth gives a zero result
  logic [QB-1:0]        cqx, cqy;
  logic signed [QB+2:0] sx, sy, dx, dy;
  logic                 hix, lox, hiy, loy;
  logic signed [31:0]   res_x_next, res_y_next;
  logic                 sat_next;
  always_comb begin
    cqx = (ovx[QB] || qx[QB] > QUOT_LIMIT) ? QUOT_LIMIT : qx[QB];
    cqy = (ovy[QB] || qy[QB] > QUOT_LIMIT) ? QUOT_LIMIT : qy[QB];
    sx  = ngx[QB] ? -$signed({3'b0, cqx}) : $signed({3'b0, cqx});
    sy  = ngy[QB] ? -$signed({3'b0, cqy}) : $signed({3'b0, cqy});
    dx  = sx - (QB+3)'(obd[QB][0]);
    dy  = sy - (QB+3)'(obd[QB][1]);
    hix = dx > (QB+3)'(RES_MAX);
    lox = dx < (QB+3)'(RES_MIN);
    hiy = dy > (QB+3)'(RES_MAX);
    loy = dy < (QB+3)'(RES_MIN);
    res_x_next = hix ? RES_MAX : (lox ? RES_MIN : dx[31:0]);
    res_y_next = hiy ? RES_MAX : (loy ? RES_MIN : dy[31:0]);
    sat_next   = hix || lox || hiy || loy;
    if (zr[QB]) begin
      res_x_next = '0;
      res_y_next = '0;
      sat_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {res_y_next, res_x_next};
      m_tuser <= {sat_next, zr[QB]};
    end
  end

  // valid bits; v5 marks the stage 5 data that the divider set-up registers take
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      for (int k = 0; k <= QB; k++) dv[k] <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      dv[0] <= v5;
      for (int k = 0; k < QB; k++) dv[k+1] <= dv[k];
      m_tvalid <= dv[QB];
    end
  end

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("depth_invalid and saturated both set");
  a_zero_res: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("invalid depth with nonzero residual");
  a_sat_lim: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |->
      ($signed(m_tdata[31:0]) == RES_MAX || $signed(m_tdata[31:0]) == RES_MIN ||
       $signed(m_tdata[63:32]) == RES_MAX || $signed(m_tdata[63:32]) == RES_MIN))
    else $error("saturated without a residual at a limit");
endmodule
`default_nettype wire

[tb/tb_reprojection_residual.sv]
module tb_reprojection_residual;
  import rr_pkg::*;

  localparam int CF = COORD_FRAC_BITS_DEF;
  localparam int QF = QUAT_FRAC_BITS_DEF;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic signed [31:0] obs_y, obs_x, pz, py, px, tz, ty, tx, qz, qy, qx, qw;
  } obs_t;

  typedef struct packed {
    logic        sat;
    logic        dinv;
    logic [31:0] ry;
    logic [31:0] rx;
  } res_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [383:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [63:0] m_tdata;
  logic [1:0] m_tuser;

  reprojection_residual uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  obs_t pending[$];
  res_t residuals_due[$];
  int errors = 0;
  int phase = 0;
  int hold_left = 0;
  bit hold_done = 0;
  bit stim_done = 0;
  int idle_cycles = 0;

  function automatic void queue_obs(obs_t o);
    pending.insert(pending.size(), o);
  endfunction

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_one(longint v);
    longint one;
    one = 64'sd1 <<< QF;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic longint divide_depth(longint num, longint den);
    logic [127:0] n, d, q;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = 128'((num < 0) ? -num : num);
    d = 128'((den < 0) ? -den : den);
    q = (n << CF) / d;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sat32(longint v, inout bit clip);
    if (v > 64'sd2147483647) begin clip = 1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin clip = 1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic res_t project_residual(obs_t o);
    longint w, x, y, z, xx, yy, zz, xy, xz, yz, wx, wy, wz, one, half;
    longint r[3][3];
    longint v[3], t[3], p[3];
    longint acc;
    res_t res;
    bit clip;
    w = o.qw; x = o.qx; y = o.qy; z = o.qz;
    one = 64'sd1 <<< QF;
    half = 64'sd1 <<< (QF - 1);
    xx = floor_sh(x * x, QF - 1); yy = floor_sh(y * y, QF - 1);
    zz = floor_sh(z * z, QF - 1); xy = floor_sh(x * y, QF - 1);
    xz = floor_sh(x * z, QF - 1); yz = floor_sh(y * z, QF - 1);
    wx = floor_sh(w * x, QF - 1); wy = floor_sh(w * y, QF - 1);
    wz = floor_sh(w * z, QF - 1);
    r[0][0] = clamp_one(one - yy - zz); r[0][1] = clamp_one(xy - wz);
    r[0][2] = clamp_one(xz + wy);       r[1][0] = clamp_one(xy + wz);
    r[1][1] = clamp_one(one - xx - zz); r[1][2] = clamp_one(yz - wx);
    r[2][0] = clamp_one(xz - wy);       r[2][1] = clamp_one(yz + wx);
    r[2][2] = clamp_one(one - xx - yy);
    v[0] = o.px; v[1] = o.py; v[2] = o.pz;
    t[0] = o.tx; t[1] = o.ty; t[2] = o.tz;
    for (int i = 0; i < 3; i++) begin
      acc = r[i][0] * v[0] + r[i][1] * v[1] + r[i][2] * v[2];
      p[i] = floor_sh(acc + half, QF) + t[i];
    end
    res = '0;
    clip = 0;
    if (p[2] == 0) begin
      res.dinv = 1;
    end else begin
      res.rx = 32'(sat32(divide_depth(p[0], p[2]) - longint'(o.obs_x), clip));
      res.ry = 32'(sat32(divide_depth(p[1], p[2]) - longint'(o.obs_y), clip));
      res.sat = clip;
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
      2: return $signed($urandom_range(0, 1 << 16)) - (1 << 15);
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  // near-unit quaternion from a random direction, scaled toward 2^30; one call in ten is all random
  function automatic obs_t rand_obs();
    obs_t o;
    real a, b, c, d, n;
    if ($urandom_range(0, 9) == 0) begin
      o = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      return o;
    end
    a = $signed($urandom_range(0, 2000)) - 1000;
    b = $signed($urandom_range(0, 2000)) - 1000;
    c = $signed($urandom_range(0, 2000)) - 1000;
    d = $signed($urandom_range(0, 2000)) - 1000;
    n = $sqrt(a * a + b * b + c * c + d * d) + 1e-9;
    o.qw = $rtoi(a / n * 1073741823.0);
    o.qx = $rtoi(b / n * 1073741823.0);
    o.qy = $rtoi(c / n * 1073741823.0);
    o.qz = $rtoi(d / n * 1073741823.0);
    o.tx = rand_coord(); o.ty = rand_coord();
    o.tz = $urandom_range(0, 3) == 0 ? rand_coord() : $urandom_range(1 << 16, 30 << 16);
    o.px = rand_coord(); o.py = rand_coord(); o.pz = rand_coord();
    o.obs_x = rand_coord(); o.obs_y = rand_coord();
    return o;
  endfunction

  function automatic obs_t basic_obs(logic signed [31:0] qw, qx, qy, qz, tz, px, py, pz);
    obs_t o;
    o = '0;
    o.qw = qw; o.qx = qx; o.qy = qy; o.qz = qz; o.tz = tz;
    o.px = px; o.py = py; o.pz = pz;
    return o;
  endfunction

  initial begin
    obs_t o;
    queue_obs(basic_obs(32'sh40000000, 0, 0, 0, 32'sh00050000, 32'sh10000,
                        32'sh20000, 0));
    // zero depth
    queue_obs(basic_obs(32'sh40000000, 0, 0, 0, 0, 32'sh10000, 32'sh10000, 0));
    // negative depth
    queue_obs(basic_obs(32'sh40000000, 0, 0, 0, -32'sh30000, 32'sh10000,
                        -32'sh10000, 0));
    // tiny depth drives the quotient into saturation
    queue_obs(basic_obs(32'sh40000000, 0, 0, 0, 1, 32'sh7fffffff,
                        32'sh80000000, 0));
    // 90 degrees about z and about x
    queue_obs(basic_obs(32'sh2d413ccd, 0, 0, 32'sh2d413ccd, 32'sh40000,
                        32'sh10000, 0, 32'sh10000));
    queue_obs(basic_obs(32'sh2d413ccd, 32'sh2d413ccd, 0, 0, 32'sh40000,
                        0, 32'sh10000, 0));
    // non-unit quaternions, extremes
    queue_obs(basic_obs(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                        32'sh7fffffff, 32'sh10000, 32'sh7fffffff,
                        32'sh7fffffff, 32'sh7fffffff));
    queue_obs(basic_obs(32'sh80000000, 32'sh80000000, 32'sh80000000,
                        32'sh80000000, 32'sh80000000, 32'sh80000000,
                        32'sh80000000, 32'sh80000000));
    queue_obs(basic_obs(0, 0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000, 0));
    o = basic_obs(32'sh40000000, 0, 0, 0, 32'sh10000, 0, 0, 0);
    o.obs_x = 32'sh7fffffff; o.obs_y = 32'sh80000000;
    queue_obs(o);
    o = '1;
    queue_obs(o);
    o.tx = 32'sh7fffffff; o.ty = 32'sh80000000; o.tz = 32'sh7fffffff;
    queue_obs(o);
    for (int i = 0; i < 450; i++) queue_obs(rand_obs());
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        residuals_due.insert(residuals_due.size(), project_residual(s_tdata));
      end
      if (!s_tvalid || s_tready) begin
        if (pending.size() > 0 &&
            !((phase == 1 || phase == 3) && $urandom_range(0, 99) < (phase == 1 ? 51 : 7))) begin
          s_tdata <= pending.pop_front();
          s_tvalid <= 1;
          if (pending.size() % 60 == 0) phase <= (phase + 1) % 4;
        end else begin
          s_tvalid <= 0;
          if (pending.size() == 0) stim_done <= 1;
        end
      end
    end
  end

  // receiver: long hold-off once, otherwise stall per phase
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (!hold_done && pending.size() == 200) begin
        hold_left <= 300;
        hold_done <= 1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
      if (hold_left > 1) m_tready <= 0;
      else if (phase == 2) m_tready <= $urandom_range(0, 99) >= 51;
      else if (phase == 3) m_tready <= $urandom_range(0, 99) >= 7;
      else m_tready <= 1;
    end
  end

  // cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata};
      if (residuals_due.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors = errors + 1;
      end else begin
        want = residuals_due.pop_front();
        if (got.rx !== want.rx) begin
          $display("%0t: residual_x exp %h got %h", $time, want.rx, got.rx);
          errors = errors + 1;
        end
        if (got.ry !== want.ry) begin
          $display("%0t: residual_y exp %h got %h", $time, want.ry, got.ry);
          errors = errors + 1;
        end
        if (got.dinv !== want.dinv) begin
          $display("%0t: depth_invalid exp %b got %b", $time, want.dinv, got.dinv);
          errors = errors + 1;
        end
        if (got.sat !== want.sat) begin
          $display("%0t: saturated exp %b got %b", $time, want.sat, got.sat);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    wait (stim_done && !s_tvalid && residuals_due.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && residuals_due.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

[reprojection_residual.f]
hdl/rr_pkg.sv
hdl/reprojection_residual.sv
tb/tb_reprojection_residual.sv
